FILE: hw/rtl/fdtd_pkg.sv
// shared types and constants for the 2d tmz field update engine
`default_nettype none
package fdtd_pkg;

	localparam int FIELD_W = 32;
	localparam int CFG_W   = 7;

	// item operations
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_ESWEEP = 2'd2,
		OP_HSWEEP = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [0:0] CFG_COLS = 1'b0;
	localparam logic [0:0] CFG_ROWS = 1'b1;

	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

	typedef logic signed [FIELD_W-1:0] field_t;

	typedef struct packed {
		field_t ee;
		field_t eh;
		field_t xh;
		field_t xe;
		field_t yh;
		field_t ye;
	} coef_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] col;
		logic [5:0] row;
		field_t     e_in;
		field_t     h1_in;
		field_t     h2_in;
		field_t     coef_ee;
		field_t     coef_eh;
		field_t     coef_xh;
		field_t     coef_xe;
		field_t     coef_yh;
		field_t     coef_ye;
	} in_item_t;

	typedef struct packed {
		field_t e_out;
		field_t h1_out;
		field_t h2_out;
		logic   saturated;
	} out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fdtd_stream_if.sv
// valid/ready channel carrying one payload per transaction
`default_nettype none
interface fdtd_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/fdtd_2d_tm_field_update_core.sv
// 2d tmz fdtd grid engine: field and coefficient memories with a per-cell update sequencer
//
//  channel   | dir | payload     | transaction
//  ----------+-----+-------------+----------------------------------------------
//  in_item   | in  | in_item_t   | write cell, read cell, e sweep or h sweep
//  out_item  | out | out_item_t  | one result per item
//  cfg       | in  | index, data | cols_in_use / rows_in_use write, no handshake
//
//  write passes through the emit state, read through a read wait and emit;
//  sweeps take each cell in phases, paced by the single shared 32x32 multiplier and
//  the single read port of each field memory (neighbor reads go one after another).
//  after reset a clearing pass zeroes every cell of the field memories, with
//  in_item not ready; configuration writes are taken meanwhile.
//  one item is in work at a time; a finished result waits in the output
//  register while the next item is accepted and processed.
`default_nettype none
module fdtd_2d_tm_field_update_core #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [fdtd_pkg::CFG_W-1:0] cfg_wdata,
	fdtd_stream_if.sink                in_item,
	fdtd_stream_if.source              out_item
);
	import fdtd_pkg::*;

	localparam int NCELLS = MAX_COLS * MAX_ROWS;
	localparam int AW     = $clog2(NCELLS);
	localparam int CNT_W  = ($clog2(MAX_COLS + 1) > $clog2(MAX_ROWS + 1)) ?
	                        $clog2(MAX_COLS + 1) : $clog2(MAX_ROWS + 1);
	localparam int NW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_CELL,
		ST_EMIT
	} state_t;

	// saturate a wide signed value to 32 bits
	function automatic field_t sat_val(input logic signed [48:0] v);
		logic clip;
		clip = (v[48:31] != {18{v[31]}});
		if (!clip) return v[31:0];
		return v[48] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	function automatic logic sat_clip(input logic signed [48:0] v);
		return (v[48:31] != {18{v[31]}});
	endfunction

	state_t          st_q;
	logic [AW-1:0]   clr_q;
	logic [CFG_W-1:0] cols_q, rows_q;
	logic            out_v_q;
	out_item_t       out_d_q;
	field_t          res_e_q, res_x_q, res_y_q;
	logic            sat_q;
	logic            rdok_q;
	logic            is_e_q;
	logic [2:0]      ph_q;
	logic [NW-1:0]   c_q, r_q, lim_c_q, lim_r_q;
	logic [AW-1:0]   n_q, rb_q;

	// datapath registers
	field_t              a_q, b_q, c_fld_q, d1_q, d2_q;
	coef_t               coef_q;
	logic signed [63:0]  p_q;
	logic signed [47:0]  acc_q;

	// memory ports
	field_t        ez_mem [NCELLS];
	field_t        hx_mem [NCELLS];
	field_t        hy_mem [NCELLS];
	coef_t         coef_mem [NCELLS];
	field_t        ez_rd, hx_rd, hy_rd;
	coef_t         coef_rd;
	logic [AW-1:0] ez_ra, hx_ra, hy_ra, f_wa;
	logic          ez_we, hx_we, hy_we, coef_we;
	field_t        ez_wd, hx_wd, hy_wd;

	logic              in_acc;
	in_item_t          d;
	logic [AW-1:0]     in_addr;
	logic              on_grid;
	logic [NW-1:0]     nc, nr;
	logic              empty;
	logic [NW-1:0]     c0;
	logic signed [47:0] sh;
	logic signed [48:0] sum, dv;
	field_t            sum_val, dv_val;
	logic              sum_clip, dv_clip;
	field_t            ma, mb;

	assign d       = in_item.data;
	assign in_acc  = in_item.valid && in_item.ready;
	assign in_item.ready  = (st_q == ST_IDLE);
	assign out_item.valid = out_v_q;
	assign out_item.data  = out_d_q;

	assign in_addr = AW'(32'(d.col) + 32'(d.row) * 32'(MAX_COLS));
	assign on_grid = (32'(d.col) < 32'(MAX_COLS)) && (32'(d.row) < 32'(MAX_ROWS));

	// effective sweep size
	assign nc    = (NW'(cols_q) > NW'(MAX_COLS)) ? NW'(MAX_COLS) : NW'(cols_q);
	assign nr    = (NW'(rows_q) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(rows_q);
	assign empty = (nc < NW'(2)) || (nr < NW'(2));
	assign c0    = is_e_q ? NW'(1) : NW'(0);

	// product scaling and accumulate
	assign sh  = p_q[63:16];
	assign sum = (is_e_q || ph_q == 3'd7) ? (49'(acc_q) + 49'(sh)) : (49'(acc_q) - 49'(sh));
	assign sum_val  = sat_val(sum);
	assign sum_clip = sat_clip(sum);

	// curl or e difference
	assign dv = is_e_q ? ((49'(c_fld_q) - 49'(hy_rd)) - (49'(b_q) - 49'(hx_rd)))
	                   : (49'(ez_rd) - 49'(a_q));
	assign dv_val  = sat_val(dv);
	assign dv_clip = sat_clip(dv);

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		if (st_q == ST_CELL) begin
			if (is_e_q) begin
				case (ph_q)
					3'd2: begin ma = coef_q.ee; mb = a_q; end
					3'd3: begin ma = coef_q.eh; mb = d1_q; end
					default: ;
				endcase
			end else begin
				case (ph_q)
					3'd3: begin ma = coef_q.xh; mb = b_q; end
					3'd4: begin ma = coef_q.xe; mb = d1_q; end
					3'd5: begin ma = coef_q.yh; mb = c_fld_q; end
					3'd6: begin ma = coef_q.ye; mb = d2_q; end
					default: ;
				endcase
			end
		end
	end

	// memory address and write control
	always_comb begin
		ez_ra   = n_q;
		hx_ra   = n_q;
		hy_ra   = n_q;
		f_wa    = n_q;
		ez_we   = 1'b0;
		hx_we   = 1'b0;
		hy_we   = 1'b0;
		coef_we = 1'b0;
		ez_wd   = sum_val;
		hx_wd   = sum_val;
		hy_wd   = sum_val;
		unique case (st_q)
			ST_CLEAR: begin
				f_wa  = clr_q;
				ez_we = 1'b1;
				hx_we = 1'b1;
				hy_we = 1'b1;
				ez_wd = '0;
				hx_wd = '0;
				hy_wd = '0;
			end
			ST_IDLE: begin
				ez_ra = in_addr;
				hx_ra = in_addr;
				hy_ra = in_addr;
				f_wa  = in_addr;
				ez_wd = d.e_in;
				hx_wd = d.h1_in;
				hy_wd = d.h2_in;
				if (in_acc && d.op == OP_WRITE && on_grid) begin
					ez_we   = 1'b1;
					hx_we   = 1'b1;
					hy_we   = 1'b1;
					coef_we = 1'b1;
				end
			end
			ST_CELL: begin
				if (is_e_q) begin
					if (ph_q == 3'd1) begin
						hx_ra = n_q - AW'(MAX_COLS);
						hy_ra = n_q - AW'(1);
					end
					ez_we = (ph_q == 3'd4);
				end else begin
					if (ph_q == 3'd1) ez_ra = n_q + AW'(MAX_COLS);
					if (ph_q == 3'd2) ez_ra = n_q + AW'(1);
					hx_we = (ph_q == 3'd5);
					hy_we = (ph_q == 3'd7);
				end
			end
			default: ;
		endcase
	end

	// field and coefficient memories
	always_ff @(posedge clk) begin
		if (ez_we) ez_mem[f_wa] <= ez_wd;
		if (hx_we) hx_mem[f_wa] <= hx_wd;
		if (hy_we) hy_mem[f_wa] <= hy_wd;
		if (coef_we) coef_mem[f_wa] <= '{ee: d.coef_ee, eh: d.coef_eh, xh: d.coef_xh,
		                                 xe: d.coef_xe, yh: d.coef_yh, ye: d.coef_ye};
		ez_rd   <= ez_mem[ez_ra];
		hx_rd   <= hx_mem[hx_ra];
		hy_rd   <= hy_mem[hy_ra];
		coef_rd <= coef_mem[n_q];
	end

	// cell datapath registers
	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		if (st_q == ST_CELL) begin
			case (ph_q)
				3'd1: begin
					a_q     <= ez_rd;
					b_q     <= hx_rd;
					c_fld_q <= hy_rd;
					coef_q  <= coef_rd;
				end
				3'd2: d1_q <= dv_val;
				3'd3: begin
					if (is_e_q) acc_q <= sh;
					else d2_q <= dv_val;
				end
				3'd4: if (!is_e_q) acc_q <= sh;
				3'd6: acc_q <= sh;
				default: ;
			endcase
		end
	end

	// sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLEAR;
			clr_q   <= '0;
			cols_q  <= SIZE_RESET;
			rows_q  <= SIZE_RESET;
			out_v_q <= 1'b0;
			out_d_q <= '0;
			res_e_q <= '0;
			res_x_q <= '0;
			res_y_q <= '0;
			sat_q   <= 1'b0;
			rdok_q  <= 1'b0;
			is_e_q  <= 1'b0;
			ph_q    <= '0;
			c_q     <= '0;
			r_q     <= '0;
			lim_c_q <= '0;
			lim_r_q <= '0;
			n_q     <= '0;
			rb_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_COLS: cols_q <= cfg_wdata;
					CFG_ROWS: rows_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_v_q && out_item.ready) out_v_q <= 1'b0;

			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NCELLS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc) begin
						sat_q   <= 1'b0;
						res_e_q <= '0;
						res_x_q <= '0;
						res_y_q <= '0;
						unique case (d.op)
							OP_WRITE: st_q <= ST_EMIT;
							OP_READ: begin
								rdok_q <= on_grid;
								st_q   <= ST_RDWAIT;
							end
							OP_ESWEEP, OP_HSWEEP: begin
								is_e_q  <= (d.op == OP_ESWEEP);
								ph_q    <= '0;
								r_q     <= (d.op == OP_ESWEEP) ? NW'(1) : NW'(0);
								c_q     <= (d.op == OP_ESWEEP) ? NW'(1) : NW'(0);
								lim_c_q <= (d.op == OP_ESWEEP) ? nc : nc - NW'(1);
								lim_r_q <= (d.op == OP_ESWEEP) ? nr : nr - NW'(1);
								rb_q    <= (d.op == OP_ESWEEP) ? AW'(MAX_COLS) : '0;
								n_q     <= (d.op == OP_ESWEEP) ? AW'(MAX_COLS + 1) : '0;
								st_q    <= empty ? ST_EMIT : ST_CELL;
							end
							default: ;
						endcase
					end
				end
				ST_RDWAIT: begin
					if (rdok_q) begin
						res_e_q <= ez_rd;
						res_x_q <= hx_rd;
						res_y_q <= hy_rd;
					end
					st_q <= ST_EMIT;
				end
				ST_CELL: begin
					ph_q <= ph_q + 3'd1;
					if ((ph_q == 3'd2) || (!is_e_q && ph_q == 3'd3)) begin
						if (dv_clip) sat_q <= 1'b1;
					end
					if ((is_e_q && ph_q == 3'd4) || (!is_e_q && ph_q == 3'd5) ||
					    (!is_e_q && ph_q == 3'd7)) begin
						if (sum_clip) sat_q <= 1'b1;
					end
					// advance to the next cell after its last write
					if ((is_e_q && ph_q == 3'd4) || (!is_e_q && ph_q == 3'd7)) begin
						ph_q <= '0;
						if (c_q + NW'(1) < lim_c_q) begin
							c_q <= c_q + NW'(1);
							n_q <= n_q + AW'(1);
						end else if (r_q + NW'(1) < lim_r_q) begin
							r_q  <= r_q + NW'(1);
							c_q  <= c0;
							rb_q <= rb_q + AW'(MAX_COLS);
							n_q  <= rb_q + AW'(MAX_COLS) + AW'(c0);
						end else begin
							st_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!out_v_q || out_item.ready) begin
						out_v_q <= 1'b1;
						out_d_q <= '{e_out: res_e_q, h1_out: res_x_q, h2_out: res_y_q,
						             saturated: sat_q};
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// a held result is never overwritten
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && out_v_q && !out_item.ready) |=> (st_q == ST_EMIT))
		else $error("result emitted over a pending one");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_item.ready)
		else $error("second transaction accepted while busy");

	// a sweep writes only one field memory per cycle
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CELL) |-> ($countones({ez_we, hx_we, hy_we, coef_we}) <= 1))
		else $error("sweep wrote more than one memory");

endmodule
`default_nettype wire

FILE: tb/fdtd_2d_tm_field_update_core_test.sv
// self-checking testbench for the 2d tmz fdtd grid engine
`default_nettype none
module fdtd_2d_tm_field_update_core_test;
	import fdtd_pkg::*;

	localparam int NCOL  = 64;
	localparam int NROW  = 64;
	localparam int NCELL = NCOL * NROW;
	localparam longint FMAX = 64'sd2147483647;
	localparam longint FMIN = -64'sd2147483648;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	fdtd_stream_if #(.payload_t(in_item_t))  in_if  ();
	fdtd_stream_if #(.payload_t(out_item_t)) out_if ();

	fdtd_2d_tm_field_update_core #(.MAX_COLS(NCOL), .MAX_ROWS(NROW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_item(in_if.sink), .out_item(out_if.source)
	);

	// grid model state and size registers
	field_t ez_grid [NCELL];
	field_t hx_grid [NCELL];
	field_t hy_grid [NCELL];
	coef_t  coef_grid [NCELL];
	bit     coef_loaded [NCELL];
	int     width_reg;
	int     height_reg;

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int        mismatches;
	int        results_seen;
	int        sweeps_sent;
	int        send_idle_pct;
	int        recv_idle_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20000000;
		$display("[fdtd_2d_tm_field_update_core] ERROR");
		$finish;
	end

	function automatic field_t clip32(input longint v, inout bit flag);
		if (v > FMAX) begin
			flag = 1'b1;
			return field_t'(FMAX);
		end
		if (v < FMIN) begin
			flag = 1'b1;
			return field_t'(FMIN);
		end
		return field_t'(v);
	endfunction

	// q16.16 product, floor shift
	function automatic longint qmul(input field_t a, input field_t b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> 16;
	endfunction

	function automatic bit e_sweep_model();
		bit sat;
		int nc, nr, n;
		longint curl, v;
		field_t cq;
		sat = 1'b0;
		nc = (width_reg > NCOL) ? NCOL : width_reg;
		nr = (height_reg > NROW) ? NROW : height_reg;
		for (int r = 1; r < nr; r++) begin
			for (int c = 1; c < nc; c++) begin
				n = c + r * NCOL;
				curl = (longint'(hy_grid[n]) - longint'(hy_grid[n-1]))
				     - (longint'(hx_grid[n]) - longint'(hx_grid[n-NCOL]));
				cq = clip32(curl, sat);
				v = qmul(coef_grid[n].ee, ez_grid[n]) + qmul(coef_grid[n].eh, cq);
				ez_grid[n] = clip32(v, sat);
			end
		end
		return sat;
	endfunction

	function automatic bit h_sweep_model();
		bit sat;
		int nc, nr, n;
		longint vx, vy;
		field_t dy, dx;
		sat = 1'b0;
		nc = (width_reg > NCOL) ? NCOL : width_reg;
		nr = (height_reg > NROW) ? NROW : height_reg;
		for (int r = 0; r + 1 < nr; r++) begin
			for (int c = 0; c + 1 < nc; c++) begin
				n = c + r * NCOL;
				dy = clip32(longint'(ez_grid[n+NCOL]) - longint'(ez_grid[n]), sat);
				dx = clip32(longint'(ez_grid[n+1]) - longint'(ez_grid[n]), sat);
				vx = qmul(coef_grid[n].xh, hx_grid[n]) - qmul(coef_grid[n].xe, dy);
				vy = qmul(coef_grid[n].yh, hy_grid[n]) + qmul(coef_grid[n].ye, dx);
				hx_grid[n] = clip32(vx, sat);
				hy_grid[n] = clip32(vy, sat);
			end
		end
		return sat;
	endfunction

	// expected result of one accepted transaction
	function automatic out_item_t grid_update(input in_item_t it);
		out_item_t res;
		int n;
		res = '0;
		n = int'(it.col) + int'(it.row) * NCOL;
		case (it.op)
			OP_WRITE: begin
				ez_grid[n] = it.e_in;
				hx_grid[n] = it.h1_in;
				hy_grid[n] = it.h2_in;
				coef_grid[n] = '{it.coef_ee, it.coef_eh, it.coef_xh,
					it.coef_xe, it.coef_yh, it.coef_ye};
			end
			OP_READ: begin
				res.e_out  = ez_grid[n];
				res.h1_out = hx_grid[n];
				res.h2_out = hy_grid[n];
			end
			OP_ESWEEP: res.saturated = e_sweep_model();
			default:   res.saturated = h_sweep_model();
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	// driver: present queued items and random output ready, change at falling edge
	bit in_taken;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.data  <= '0;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			if (!in_if.valid || in_taken) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_if.data  <= pending_items.pop_front();
					in_if.valid <= 1'b1;
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		in_taken <= arst_n && in_if.valid && in_if.ready;
		if (arst_n && in_if.valid && in_if.ready) begin
			expected_results.push_back(grid_update(in_if.data));
		end
		if (arst_n && out_if.valid && out_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				out_item_t want;
				want = expected_results.pop_front();
				if (out_if.data.e_out !== want.e_out)
					report_mismatch("e_out", out_if.data.e_out, want.e_out);
				if (out_if.data.h1_out !== want.h1_out)
					report_mismatch("h1_out", out_if.data.h1_out, want.h1_out);
				if (out_if.data.h2_out !== want.h2_out)
					report_mismatch("h2_out", out_if.data.h2_out, want.h2_out);
				if (out_if.data.saturated !== want.saturated)
					report_mismatch("saturated", out_if.data.saturated, want.saturated);
			end
		end
	end

	// field value: full range, small, or an extreme
	function automatic field_t pick_value();
		case ($urandom_range(9))
			0:       return field_t'(FMAX);
			1:       return field_t'(FMIN);
			2, 3:    return field_t'($urandom);
			default: return field_t'($signed($urandom_range(262143)) - 131072);
		endcase
	endfunction

	task automatic queue_item(input op_t op, input int c, input int r, input bit extreme);
		in_item_t it;
		it.op  = op;
		it.col = c[5:0];
		it.row = r[5:0];
		it.e_in    = extreme ? field_t'(FMAX) : pick_value();
		it.h1_in   = extreme ? field_t'(FMIN) : pick_value();
		it.h2_in   = extreme ? field_t'(FMAX) : pick_value();
		it.coef_ee = extreme ? field_t'(FMAX) : pick_value();
		it.coef_eh = extreme ? field_t'(FMIN) : pick_value();
		it.coef_xh = extreme ? field_t'(FMAX) : pick_value();
		it.coef_xe = extreme ? field_t'(FMIN) : pick_value();
		it.coef_yh = extreme ? field_t'(FMAX) : pick_value();
		it.coef_ye = extreme ? field_t'(FMIN) : pick_value();
		if (op == OP_WRITE)
			coef_loaded[c + r * NCOL] = 1'b1;
		if (op == OP_ESWEEP || op == OP_HSWEEP)
			sweeps_sent++;
		pending_items.push_back(it);
	endtask

	// hold off until every expected result is back
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(input logic [0:0] idx, input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_COLS)
			width_reg = value & 127;
		else
			height_reg = value & 127;
	endtask

	// random sweeps stay inside the loaded 4x4 corner
	task automatic random_phase(input int count);
		int pick;
		write_size(CFG_COLS, $urandom_range(4));
		write_size(CFG_ROWS, $urandom_range(4));
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(9);
			if (pick < 4)
				queue_item(OP_WRITE, $urandom_range(3), $urandom_range(3), 1'b0);
			else if (pick < 5)
				queue_item(OP_WRITE, $urandom_range(63), $urandom_range(63), 1'b0);
			else if (pick < 7)
				queue_item(OP_READ, $urandom_range(($urandom_range(3) == 0) ? 63 : 3),
					$urandom_range(($urandom_range(3) == 0) ? 63 : 3), 1'b0);
			else
				queue_item(pick[0] ? OP_HSWEEP : OP_ESWEEP, 0, 0, 1'b0);
		end
		wait_drained();
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COLS;
		cfg_wdata = '0;
		width_reg = int'(SIZE_RESET);
		height_reg = int'(SIZE_RESET);
		mismatches = 0;
		results_seen = 0;
		sweeps_sent = 0;
		send_idle_pct = 9;
		recv_idle_pct = 80;
		for (int n = 0; n < NCELL; n++) begin
			ez_grid[n] = '0;
			hx_grid[n] = '0;
			hy_grid[n] = '0;
			coef_grid[n] = '0;
			coef_loaded[n] = 1'b0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// load the 4x4 corner, then directed cases
		write_size(CFG_COLS, 4);
		write_size(CFG_ROWS, 4);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				queue_item(OP_WRITE, c, r, 1'b0);
		queue_item(OP_READ, 63, 63, 1'b0);
		queue_item(OP_WRITE, 63, 63, 1'b1);
		queue_item(OP_READ, 63, 63, 1'b0);
		queue_item(OP_READ, 0, 0, 1'b0);
		queue_item(OP_ESWEEP, 0, 0, 1'b0);
		queue_item(OP_HSWEEP, 0, 0, 1'b0);
		queue_item(OP_WRITE, 3, 3, 1'b1);
		queue_item(OP_WRITE, 2, 3, 1'b1);
		queue_item(OP_ESWEEP, 0, 0, 1'b0);
		queue_item(OP_HSWEEP, 0, 0, 1'b0);
		queue_item(OP_READ, 3, 3, 1'b0);
		queue_item(OP_READ, 2, 3, 1'b0);
		wait_drained();

		// degenerate sizes update nothing, a 2x2 size updates a single cell
		write_size(CFG_COLS, 1);
		write_size(CFG_ROWS, 0);
		queue_item(OP_ESWEEP, 0, 0, 1'b0);
		queue_item(OP_HSWEEP, 0, 0, 1'b0);
		queue_item(OP_READ, 4, 4, 1'b0);
		wait_drained();
		write_size(CFG_COLS, 2);
		write_size(CFG_ROWS, 2);
		queue_item(OP_ESWEEP, 0, 0, 1'b0);
		queue_item(OP_HSWEEP, 0, 0, 1'b0);
		queue_item(OP_READ, 1, 1, 1'b0);
		wait_drained();

		// random traffic under three idling patterns
		for (int p = 0; p < 2; p++) random_phase(8);
		send_idle_pct = 80;
		recv_idle_pct = 9;
		for (int p = 0; p < 2; p++) random_phase(8);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int p = 0; p < 2; p++) random_phase(8);

		// full-width row with an oversized width register
		for (int c = 1; c < NCOL; c++)
			if (!coef_loaded[c + NCOL])
				queue_item(OP_WRITE, c, 1, 1'b0);
		wait_drained();
		write_size(CFG_COLS, 127);
		write_size(CFG_ROWS, 2);
		queue_item(OP_ESWEEP, 0, 0, 1'b0);
		queue_item(OP_READ, 63, 1, 1'b0);
		queue_item(OP_READ, 32, 1, 1'b0);
		wait_drained();

		$display("covered %0d results including %0d sweeps, sizes from 0 to 127",
			results_seen, sweeps_sent);
		$display("under sender, receiver and no idling, with %0d mismatches", mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[fdtd_2d_tm_field_update_core] OK");
		else
			$display("[fdtd_2d_tm_field_update_core] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
